@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define WSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked in reset too.
`define WSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define WSP_ASSERT(lbl, prop)
`define WSP_ASSERT_RST(lbl, prop)
`endif
`endif

@@ src/wsp_pkg.sv @@
package wsp_pkg;

  localparam int NQ   = 21;            // quotient bits
  localparam int NSTG = 5 + NQ + 1;    // total pipeline stages
  localparam int W_CLIP = 42;
  localparam int W_NUM  = 43;
  localparam int W_PROD = 58;
  localparam int W_REM  = 65;
  localparam int W_D    = 43;

  localparam logic [2:0] REG_COEF_X    = 3'd0;
  localparam logic [2:0] REG_COEF_Y    = 3'd1;
  localparam logic [2:0] REG_COEF_Z    = 3'd2;
  localparam logic [2:0] REG_OFFSET_XY = 3'd3;
  localparam logic [2:0] REG_OFFSET_ZW = 3'd4;
  localparam logic [2:0] REG_WIDTH     = 3'd5;
  localparam logic [2:0] REG_HEIGHT    = 3'd6;

  localparam logic [63:0] RST_COEF_X    = 64'h0000_0000_0000_1000;
  localparam logic [63:0] RST_COEF_Y    = 64'h0000_0000_1000_0000;
  localparam logic [63:0] RST_COEF_Z    = 64'h0000_1000_0000_0000;
  localparam logic [63:0] RST_OFFSET_XY = 64'h0;
  localparam logic [63:0] RST_OFFSET_ZW = 64'h0000_1000_0000_0000;
  localparam logic [13:0] RST_WIDTH     = 14'd1920;
  localparam logic [13:0] RST_HEIGHT    = 14'd1080;

  localparam logic signed [20:0] SCR_MAX = 21'sd1048575;
  localparam logic signed [20:0] SCR_MIN = -21'sd1048576;

  typedef struct packed {
    logic [W_REM-1:0] m;
    logic [W_D-1:0]   d;
    logic             neg;
    logic             ovf;
  } div_in_t;

  typedef struct packed {
    logic [NQ-1:0] q;
    logic          neg;
    logic          ovf;
  } div_out_t;

endpackage

@@ src/wsp_clip.sv @@
module wsp_clip (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic signed [23:0]                world_x,
  input  logic signed [23:0]                world_y,
  input  logic signed [23:0]                world_z,
  input  logic [63:0]                       coef_x,
  input  logic [63:0]                       coef_y,
  input  logic [63:0]                       coef_z,
  input  logic [63:0]                       offset_xy,
  input  logic [63:0]                       offset_zw,
  output logic signed [wsp_pkg::W_NUM-1:0]  num_x,
  output logic signed [wsp_pkg::W_NUM-1:0]  num_y,
  output logic signed [wsp_pkg::W_CLIP-1:0] clip_w,
  output logic                              vis
);

  localparam int W_CLIP = wsp_pkg::W_CLIP;
  localparam int W_NUM  = wsp_pkg::W_NUM;

  // clip z never reaches a result, so only lanes 0, 1 and 3 are built
  logic signed [39:0] pr_r [9];
  logic signed [39:0] pr_nxt [9];
  logic signed [wsp_pkg::W_CLIP-1:0] cl_r [3];
  logic signed [wsp_pkg::W_CLIP-1:0] cl_nxt [3];
  logic signed [wsp_pkg::W_CLIP-1:0] off [3];
  logic signed [23:0] pt [3];
  logic [63:0] col [3];
  logic signed [45:0] w10;
  logic signed [wsp_pkg::W_NUM-1:0] numx_r, numy_r;
  logic signed [wsp_pkg::W_CLIP-1:0] w_r;
  logic vis_r;

  always_comb begin
    pt[0] = world_x;
    pt[1] = world_y;
    pt[2] = world_z;
    col[0] = coef_x;
    col[1] = coef_y;
    col[2] = coef_z;
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i]     = pt[i] * $signed(col[i][15:0]);
      pr_nxt[3 + i] = pt[i] * $signed(col[i][31:16]);
      pr_nxt[6 + i] = pt[i] * $signed(col[i][63:48]);
    end
  end

  // Q20.12 offsets scaled to Q.16
  always_comb begin
    off[0] = {{6{offset_xy[31]}}, offset_xy[31:0], 4'b0};
    off[1] = {{6{offset_xy[63]}}, offset_xy[63:32], 4'b0};
    off[2] = {{6{offset_zw[63]}}, offset_zw[63:32], 4'b0};
    for (int c = 0; c < 3; c++) begin
      cl_nxt[c] = off[c] + W_CLIP'(pr_r[3*c]) + W_CLIP'(pr_r[3*c+1])
                + W_CLIP'(pr_r[3*c+2]);
    end
  end

  assign w10 = 46'(cl_r[2]) * 46'sd10;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) pr_r[i] <= pr_nxt[i];
    end
    if (en[1]) begin
      for (int c = 0; c < 3; c++) cl_r[c] <= cl_nxt[c];
    end
    if (en[2]) begin
      numx_r <= W_NUM'(cl_r[2]) + W_NUM'(cl_r[0]);
      numy_r <= W_NUM'(cl_r[2]) - W_NUM'(cl_r[1]);
      w_r    <= cl_r[2];
      vis_r  <= (w10 >= 46'sd65536);
    end
  end

  assign num_x  = numx_r;
  assign num_y  = numy_r;
  assign clip_w = w_r;
  assign vis    = vis_r;

endmodule

@@ src/wsp_scale.sv @@
module wsp_scale (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [wsp_pkg::W_NUM-1:0]  num_x,
  input  logic signed [wsp_pkg::W_NUM-1:0]  num_y,
  input  logic signed [wsp_pkg::W_CLIP-1:0] clip_w,
  input  logic [13:0]                       scr_w,
  input  logic [13:0]                       scr_h,
  output wsp_pkg::div_in_t                  div_x,
  output wsp_pkg::div_in_t                  div_y
);

  logic signed [wsp_pkg::W_PROD-1:0] nx_r, ny_r;
  logic signed [wsp_pkg::W_CLIP-1:0] w_r;
  wsp_pkg::div_in_t dx_r, dy_r;

  // numerator 2n + w with n = size*num*8; floor of a negative N is the
  // complement of the floor of ~N
  function automatic wsp_pkg::div_in_t prep(
    input logic signed [wsp_pkg::W_PROD-1:0] n,
    input logic signed [wsp_pkg::W_CLIP-1:0] w
  );
    logic signed [63:0] nn;
    logic [63:0] mag;
    wsp_pkg::div_in_t r;
    nn    = ({{2{n[wsp_pkg::W_PROD-1]}}, n, 4'b0}) + 64'(w);
    mag   = nn[63] ? ~nn : nn;
    r.m   = {1'b0, mag};
    r.d   = {w, 1'b0};
    r.neg = nn[63];
    r.ovf = ({1'b0, mag} >= {1'b0, r.d, 21'b0});
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nx_r <= $signed({1'b0, scr_w}) * num_x;
      ny_r <= $signed({1'b0, scr_h}) * num_y;
      w_r  <= clip_w;
    end
    if (en[1]) begin
      dx_r <= prep(nx_r, w_r);
      dy_r <= prep(ny_r, w_r);
    end
  end

  assign div_x = dx_r;
  assign div_y = dy_r;

endmodule

@@ src/wsp_div.sv @@
module wsp_div (
  input  logic                   clk,
  input  logic [wsp_pkg::NQ-1:0] en,
  input  wsp_pkg::div_in_t       din,
  output wsp_pkg::div_out_t      dout
);

  localparam int NQ    = wsp_pkg::NQ;
  localparam int W_REM = wsp_pkg::W_REM;

  // one quotient bit per stage, most significant first
  logic [W_REM-1:0]     rem_r [NQ];
  logic [wsp_pkg::W_D-1:0] d_r [NQ];
  logic [NQ-1:0]        q_r   [NQ];
  logic [NQ-1:0]        neg_r, ovf_r;

  for (genvar j = 0; j < NQ; j++) begin : g_stg
    logic [W_REM-1:0]        rin;
    logic [wsp_pkg::W_D-1:0] din_d;
    logic [NQ-1:0]           qin;
    logic                    nin, oin;
    logic [W_REM-1:0]        sh;
    logic                    ge;
    if (j == 0) begin : g_first
      assign rin   = din.m;
      assign din_d = din.d;
      assign qin   = '0;
      assign nin   = din.neg;
      assign oin   = din.ovf;
    end else begin : g_next
      assign rin   = rem_r[j-1];
      assign din_d = d_r[j-1];
      assign qin   = q_r[j-1];
      assign nin   = neg_r[j-1];
      assign oin   = ovf_r[j-1];
    end
    assign sh = W_REM'(din_d) << (NQ - 1 - j);
    assign ge = (rin >= sh);
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= ge ? rin - sh : rin;
        d_r[j]   <= din_d;
        q_r[j]   <= {qin[NQ-2:0], ge};
        neg_r[j] <= nin;
        ovf_r[j] <= oin;
      end
    end
  end

  assign dout.q   = q_r[NQ-1];
  assign dout.neg = neg_r[NQ-1];
  assign dout.ovf = ovf_r[NQ-1];

endmodule

@@ src/world_to_screen_projection.sv @@
// Projects world points to screen pixels.
// Input stream: one point per request, in_tdata = world_x, world_y, world_z,
// each signed Q19.4. Output stream: one result per point, out_tdata =
// visible, screen_x, screen_y (signed Q16.4, saturated; zero when the point
// is behind or too close to the eye, clip w below 0.1).
// Matrix columns, offsets and viewport size are written through cfg_wen /
// cfg_index / cfg_wdata; the user must write them only while the pipe is
// empty, as the block does not enforce it. A bad index is dropped.
// Throughput is one point per cycle while out_tready stays high; the depth
// is set by the 21-stage restoring quotient pipeline (one quotient bit per
// stage) plus five stages of multiply and sum and one output register.
// Reset empties the pipe and loads an identity matrix, w offset 1.0 and a
// 1920x1080 viewport. When out_tready is low the pipe keeps its data; empty
// stages still fill, so in_tready stays high until every stage holds a point.
`include "assert_macros.svh"
module world_to_screen_projection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // world_x, world_y, world_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // visible, screen_x, screen_y, 5 bits zero
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int NQ   = wsp_pkg::NQ;
  localparam int NSTG = wsp_pkg::NSTG;

  logic [63:0] coef_x_r, coef_y_r, coef_z_r, off_xy_r, off_zw_r;
  logic [13:0] scr_w_r, scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= wsp_pkg::RST_COEF_X;
      coef_y_r <= wsp_pkg::RST_COEF_Y;
      coef_z_r <= wsp_pkg::RST_COEF_Z;
      off_xy_r <= wsp_pkg::RST_OFFSET_XY;
      off_zw_r <= wsp_pkg::RST_OFFSET_ZW;
      scr_w_r  <= wsp_pkg::RST_WIDTH;
      scr_h_r  <= wsp_pkg::RST_HEIGHT;
    end else if (cfg_wen) begin
      case (cfg_index)
        wsp_pkg::REG_COEF_X:    coef_x_r <= cfg_wdata;
        wsp_pkg::REG_COEF_Y:    coef_y_r <= cfg_wdata;
        wsp_pkg::REG_COEF_Z:    coef_z_r <= cfg_wdata;
        wsp_pkg::REG_OFFSET_XY: off_xy_r <= cfg_wdata;
        wsp_pkg::REG_OFFSET_ZW: off_zw_r <= cfg_wdata;
        wsp_pkg::REG_WIDTH:     scr_w_r  <= cfg_wdata[13:0];
        wsp_pkg::REG_HEIGHT:    scr_h_r  <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // stage valids; a stage loads when empty or when the next one moves
  logic [NSTG-1:0] v_r, en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_tready = en[0];

  logic signed [wsp_pkg::W_NUM-1:0]  num_x, num_y;
  logic signed [wsp_pkg::W_CLIP-1:0] clip_w;
  logic vis;
  wsp_pkg::div_in_t  dvx, dvy;
  wsp_pkg::div_out_t qx, qy;

  wsp_clip u_clip (
    .clk       (clk),
    .en        (en[2:0]),
    .world_x   ($signed(in_tdata[23:0])),
    .world_y   ($signed(in_tdata[47:24])),
    .world_z   ($signed(in_tdata[71:48])),
    .coef_x    (coef_x_r),
    .coef_y    (coef_y_r),
    .coef_z    (coef_z_r),
    .offset_xy (off_xy_r),
    .offset_zw (off_zw_r),
    .num_x     (num_x),
    .num_y     (num_y),
    .clip_w    (clip_w),
    .vis       (vis)
  );

  wsp_scale u_scale (
    .clk    (clk),
    .en     (en[4:3]),
    .num_x  (num_x),
    .num_y  (num_y),
    .clip_w (clip_w),
    .scr_w  (scr_w_r),
    .scr_h  (scr_h_r),
    .div_x  (dvx),
    .div_y  (dvy)
  );

  wsp_div u_div_x (.clk(clk), .en(en[5 +: NQ]), .din(dvx), .dout(qx));
  wsp_div u_div_y (.clk(clk), .en(en[5 +: NQ]), .din(dvy), .dout(qy));

  // visible flag rides along stages 3 .. NSTG-2
  logic vp_r [NSTG-4];

  for (genvar j = 0; j < NSTG - 4; j++) begin : g_vis
    always_ff @(posedge clk) begin
      if (en[j+3]) vp_r[j] <= (j == 0) ? vis : vp_r[(j == 0) ? 0 : j-1];
    end
  end

  function automatic logic [20:0] finish(input wsp_pkg::div_out_t d);
    logic sat;
    sat = d.ovf || d.q[NQ-1];
    if (d.neg) return sat ? wsp_pkg::SCR_MIN : ~d.q;
    return sat ? wsp_pkg::SCR_MAX : d.q;
  endfunction

  logic        ovis_r;
  logic [20:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      ovis_r <= vp_r[NSTG-5];
      sx_r   <= vp_r[NSTG-5] ? finish(qx) : '0;
      sy_r   <= vp_r[NSTG-5] ? finish(qy) : '0;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {5'b0, sy_r, sx_r, ovis_r};

  `WSP_ASSERT_RST(a_rst_empty, !rst_n |=> (v_r == '0))
  `WSP_ASSERT(a_bubble_accept, (v_r != '1) |-> in_tready)
  `WSP_ASSERT(a_hidden_zero, (out_tvalid && !out_tdata[0]) |-> (out_tdata[42:1] == '0))

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic               vis;
    logic signed [20:0] sx;
    logic signed [20:0] sy;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               typed;
    pixel_t             px;
  } point_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;     // world_x, world_y, world_z
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;    // visible, screen_x, screen_y, zero pad
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  world_to_screen_projection i_dut (.*);

  // shadow registers
  logic [63:0] m_coef [3];
  logic [63:0] m_off_xy, m_off_zw;
  logic [13:0] m_width, m_height;

  pixel_t pending_px [$];
  int     errs = 0;
  bit     idle_on = 1;
  bit     hold_req = 0;
  point_row_t dir_tab [14];

  initial clk = 0;
  always #6 clk = ~clk;

  function automatic longint coef_lane(logic [63:0] col, int k);
    logic signed [15:0] v;
    v = col[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic logic signed [20:0] to_pixel(longint size, longint num, longint w);
    longint n, a, b, q;
    n = size * num * 8;
    a = 2 * n + w;
    b = 2 * w;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    if (q > longint'(wsp_pkg::SCR_MAX)) q = longint'(wsp_pkg::SCR_MAX);
    if (q < longint'(wsp_pkg::SCR_MIN)) q = longint'(wsp_pkg::SCR_MIN);
    return q[20:0];
  endfunction

  function automatic pixel_t project_point(logic signed [23:0] x, logic signed [23:0] y,
                                           logic signed [23:0] z);
    longint p [3];
    longint clip [4];
    logic signed [31:0] o [4];
    pixel_t r;
    p[0] = longint'(x);
    p[1] = longint'(y);
    p[2] = longint'(z);
    o[0] = m_off_xy[31:0];
    o[1] = m_off_xy[63:32];
    o[2] = m_off_zw[31:0];
    o[3] = m_off_zw[63:32];
    for (int k = 0; k < 4; k++) begin
      clip[k] = longint'(o[k]) * 16;
      for (int i = 0; i < 3; i++) clip[k] += p[i] * coef_lane(m_coef[i], k);
    end
    r = '0;
    if (clip[3] * 10 >= 65536) begin
      r.vis = 1'b1;
      r.sx = to_pixel(longint'({50'd0, m_width}), clip[3] + clip[0], clip[3]);
      r.sy = to_pixel(longint'({50'd0, m_height}), clip[3] - clip[1], clip[3]);
    end
    return r;
  endfunction

  // write enable is dropped by the next send_point
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      wsp_pkg::REG_COEF_X:    m_coef[0] = val;
      wsp_pkg::REG_COEF_Y:    m_coef[1] = val;
      wsp_pkg::REG_COEF_Z:    m_coef[2] = val;
      wsp_pkg::REG_OFFSET_XY: m_off_xy = val;
      wsp_pkg::REG_OFFSET_ZW: m_off_zw = val;
      wsp_pkg::REG_WIDTH:     m_width = val[13:0];
      wsp_pkg::REG_HEIGHT:    m_height = val[13:0];
      default: ;
    endcase
  endtask

  // entered and left at a rising edge
  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, bit typed, pixel_t px);
    cfg_wen <= 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pending_px.insert(pending_px.size(), typed ? px : project_point(x, y, z));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
      2: return $signed(24'($urandom_range(0, 255))) - 24'sd128;
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  function automatic logic [15:0] rand_lane();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191)) - 16'd4096;
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'd0;
    endcase
  endfunction

  task automatic random_setting(int kind);
    logic [63:0] c;
    for (int i = 0; i < 3; i++) begin
      c = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
      if (kind == 1) c = {4{(i == 0) ? 16'h7FFF : 16'h8000}};
      write_reg(wsp_pkg::REG_COEF_X + 3'(i), c);
    end
    write_reg(wsp_pkg::REG_OFFSET_XY,
              kind == 1 ? 64'h7FFF_FFFF_8000_0000 : {$urandom, $urandom});
    // keep w mostly positive so most points land on screen
    if (kind == 1) write_reg(wsp_pkg::REG_OFFSET_ZW, 64'h7FFF_FFFF_7FFF_FFFF);
    else write_reg(wsp_pkg::REG_OFFSET_ZW, {1'b0, 11'd0, 20'($urandom), $urandom});
    case (kind)
      1: begin
        write_reg(wsp_pkg::REG_WIDTH, 64'd16383);
        write_reg(wsp_pkg::REG_HEIGHT, 64'd0);
      end
      2: begin
        write_reg(wsp_pkg::REG_WIDTH, 64'd1);
        write_reg(wsp_pkg::REG_HEIGHT, 64'd8192);
      end
      default: begin
        write_reg(wsp_pkg::REG_WIDTH, {$urandom, $urandom});
        write_reg(wsp_pkg::REG_HEIGHT, 64'($urandom_range(1, 8192)));
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errs++;
      end else begin
        pixel_t e;
        e = pending_px.pop_front();
        if (out_tdata[0] !== e.vis) begin
          $error("visible: expected %0d, got %0d", e.vis, out_tdata[0]);
          errs++;
        end
        if (out_tdata[21:1] !== e.sx) begin
          $error("screen_x: expected %0d, got %0d", e.sx, $signed(out_tdata[21:1]));
          errs++;
        end
        if (out_tdata[42:22] !== e.sy) begin
          $error("screen_y: expected %0d, got %0d", e.sy, $signed(out_tdata[42:22]));
          errs++;
        end
      end
    end
  end

  // result side backpressure
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    #(12 * 400000);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    pixel_t none;
    none = '0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_wen = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    m_coef[0] = wsp_pkg::RST_COEF_X;
    m_coef[1] = wsp_pkg::RST_COEF_Y;
    m_coef[2] = wsp_pkg::RST_COEF_Z;
    m_off_xy = wsp_pkg::RST_OFFSET_XY;
    m_off_zw = wsp_pkg::RST_OFFSET_ZW;
    m_width = wsp_pkg::RST_WIDTH;
    m_height = wsp_pkg::RST_HEIGHT;

    // rows 0..7 with reset matrix; rows 8..13 with w taken from z
    dir_tab[0]  = '{24'sd0, 24'sd0, 24'sd0, 1'b1, '{1'b1, 21'sd15360, 21'sd8640}};
    dir_tab[1]  = '{24'sd16, 24'sd0, 24'sd0, 1'b1, '{1'b1, 21'sd30720, 21'sd8640}};
    dir_tab[2]  = '{-24'sd16, 24'sd0, 24'sd0, 1'b1, '{1'b1, 21'sd0, 21'sd8640}};
    dir_tab[3]  = '{24'sd0, 24'sd16, 24'sd0, 1'b1, '{1'b1, 21'sd15360, 21'sd0}};
    dir_tab[4]  = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 1'b1,
                    '{1'b1, wsp_pkg::SCR_MAX, wsp_pkg::SCR_MIN}};
    dir_tab[5]  = '{24'sh800000, 24'sh800000, 24'sd0, 1'b1,
                    '{1'b1, wsp_pkg::SCR_MIN, wsp_pkg::SCR_MAX}};
    dir_tab[6]  = '{24'sd0, 24'sd0, 24'sh7FFFFF, 1'b1, '{1'b1, 21'sd15360, 21'sd8640}};
    dir_tab[7]  = '{24'sd0, 24'sd0, 24'sh800000, 1'b1, '{1'b1, 21'sd15360, 21'sd8640}};
    dir_tab[8]  = '{24'sd0, 24'sd0, 24'sd0, 1'b1, none};
    dir_tab[9]  = '{24'sd50, 24'sd50, -24'sd16, 1'b1, none};
    dir_tab[10] = '{24'sd5, 24'sd7, 24'sd1, 1'b1, none};
    dir_tab[11] = '{24'sd5, -24'sd7, 24'sd2, 1'b0, none};
    dir_tab[12] = '{-24'sd300, 24'sd90, 24'sh7FFFFF, 1'b0, none};
    dir_tab[13] = '{24'sd1, 24'sd1, 24'sh800000, 1'b1, none};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 14; i++) begin
      if (i == 8) begin
        drain();
        write_reg(wsp_pkg::REG_COEF_Z, 64'h1000_0000_0000_0000);
        write_reg(wsp_pkg::REG_OFFSET_ZW, 64'd0);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);  // must be dropped
      end
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].px);
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      if (ph == 8) idle_on = 0;
      random_setting(ph == 3 ? 1 : (ph == 5 ? 2 : 0));
      if (ph == 1) hold_req = 1;
      for (int n = 0; n < 138; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
    end

    drain();
    if (errs == 0 && pending_px.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/wsp_pkg.sv
src/wsp_clip.sv
src/wsp_scale.sv
src/wsp_div.sv
src/world_to_screen_projection.sv
tb/sv/tb_top.sv
